>>> hdl/fxa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes and the result records that the ALU modules share.
// ----------------------------------------------------------------------------
package fxa_pkg;

	localparam int KIND_BITS = 5;

	localparam logic [KIND_BITS-1:0] OP_ADD       = 5'd0;
	localparam logic [KIND_BITS-1:0] OP_SUB       = 5'd1;
	localparam logic [KIND_BITS-1:0] OP_MUL       = 5'd2;
	localparam logic [KIND_BITS-1:0] OP_DIV       = 5'd3;
	localparam logic [KIND_BITS-1:0] OP_GT        = 5'd4;
	localparam logic [KIND_BITS-1:0] OP_LT        = 5'd5;
	localparam logic [KIND_BITS-1:0] OP_GE        = 5'd6;
	localparam logic [KIND_BITS-1:0] OP_LE        = 5'd7;
	localparam logic [KIND_BITS-1:0] OP_EQ        = 5'd8;
	localparam logic [KIND_BITS-1:0] OP_NE        = 5'd9;
	localparam logic [KIND_BITS-1:0] OP_MIN       = 5'd10;
	localparam logic [KIND_BITS-1:0] OP_MAX       = 5'd11;
	localparam logic [KIND_BITS-1:0] OP_INC       = 5'd12;
	localparam logic [KIND_BITS-1:0] OP_DEC       = 5'd13;
	localparam logic [KIND_BITS-1:0] OP_FROMINT   = 5'd14;
	localparam logic [KIND_BITS-1:0] OP_TOINT     = 5'd15;
	localparam logic [KIND_BITS-1:0] OP_FROMFLOAT = 5'd16;
	localparam logic [KIND_BITS-1:0] OP_TOFLOAT   = 5'd17;

	typedef struct packed {
		logic [31:0] result_raw;
		logic [31:0] result_int;
		logic [31:0] result_float;
		logic        compare_true;
		logic        div_by_zero;
		logic        overflow;
	} res_t;

	typedef struct packed {
		logic [31:0] from_raw;
		logic        from_ovf;
		logic [31:0] to_bits;
	} flt_t;

endpackage

>>> hdl/fxa_div.sv
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring division of (a << FRAC_BITS) by b, one quotient bit per stage,
// truncated toward zero, with overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
module fxa_div #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output fxa_pkg::res_t               res
);
	import fxa_pkg::*;

	localparam int QB = WORD_BITS + FRAC_BITS;

	typedef struct packed {
		logic [WORD_BITS-1:0] rem;
		logic [QB-1:0]        nq;
		logic [WORD_BITS-1:0] dvs;
		logic                 neg;
		logic                 dbz;
	} div_stage_t;

	div_stage_t           dv_sk [0:QB];
	logic [WORD_BITS:0]   trial [1:QB];
	logic [WORD_BITS:0]   diff  [1:QB];
	logic [WORD_BITS-1:0] amag;
	logic [WORD_BITS-1:0] bmag;
	logic [QB:0]          qs;
	logic [FRAC_BITS+1:0] qtop;
	logic                 qovf;
	res_t                 res_c;
	res_t                 res_q;

	assign amag = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
	assign bmag = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);

	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			trial[k] = {dv_sk[k-1].rem, dv_sk[k-1].nq[QB-1]};
			diff[k]  = trial[k] - {1'b0, dv_sk[k-1].dvs};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_sk[0].rem <= '0;
			dv_sk[0].nq  <= QB'(amag) << FRAC_BITS;
			dv_sk[0].dvs <= bmag;
			dv_sk[0].neg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			dv_sk[0].dbz <= (b == '0);
			for (int k = 1; k <= QB; k++) begin
				dv_sk[k].dvs <= dv_sk[k-1].dvs;
				dv_sk[k].neg <= dv_sk[k-1].neg;
				dv_sk[k].dbz <= dv_sk[k-1].dbz;
				// keep the difference when no borrow, else restore
				if (!diff[k][WORD_BITS]) begin
					dv_sk[k].rem <= diff[k][WORD_BITS-1:0];
					dv_sk[k].nq  <= {dv_sk[k-1].nq[QB-2:0], 1'b1};
				end else begin
					dv_sk[k].rem <= trial[k][WORD_BITS-1:0];
					dv_sk[k].nq  <= {dv_sk[k-1].nq[QB-2:0], 1'b0};
				end
			end
			res_q <= res_c;
		end
	end

	always_comb begin
		qs    = dv_sk[QB].neg ? -{1'b0, dv_sk[QB].nq} : {1'b0, dv_sk[QB].nq};
		qtop  = qs[QB:WORD_BITS-1];
		qovf  = !((&qtop) || !(|qtop));
		res_c = '0;
		if (!dv_sk[QB].dbz) begin
			res_c.result_raw = 32'(signed'(qs[WORD_BITS-1:0]));
			res_c.overflow   = qovf;
		end else begin
			res_c.div_by_zero = 1'b1;
		end
	end

	assign res = res_q;

endmodule

>>> hdl/fxa_flt.sv
// ----------------------------------------------------------------------------
// Float conversion pipeline
// Single-precision to fixed (round half away from zero, saturate) and fixed
// to single precision (round to nearest even), four register stages.
// ----------------------------------------------------------------------------
module fxa_flt #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic [31:0]                 fv,
	output fxa_pkg::flt_t               flt
);
	import fxa_pkg::*;

	localparam int MW = WORD_BITS + 23;
	localparam int NW = WORD_BITS + 24;
	localparam int PB = $clog2(WORD_BITS);
	localparam int SB = 10;
	localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] WMAX = ~WMIN;

	// float to fixed path
	logic signed [SB-1:0] sh_c;
	logic                 fneg_s2, nan_s2, inf_s2;
	logic [23:0]          man_s2;
	logic signed [SB-1:0] sh_s2;
	logic [SB-1:0]        nsh;
	logic [4:0]           nn;
	logic [24:0]          rnd;
	logic [MW-1:0]        mag_c;
	logic                 big_c;
	logic                 fneg_s3, nan_s3, big_s3;
	logic [MW-1:0]        mag_s3;
	logic [MW-1:0]        lim;
	logic                 sat;
	logic [WORD_BITS-1:0] fval;
	logic [31:0]          from_raw_s4;
	logic                 from_ovf_s4;

	// fixed to float path
	logic                 tsign_s2, tzero_s2;
	logic [WORD_BITS-1:0] tmag_s2;
	logic [PB-1:0]        tp_c;
	logic                 tsign_s3, tzero_s3;
	logic [WORD_BITS-1:0] tmag_s3;
	logic [PB-1:0]        tp_s3;
	logic                 tsign_s4, tzero_s4;
	logic [PB-1:0]        tp_s4;
	logic [NW-1:0]        norm_s4;
	logic [23:0]          m24;
	logic                 rb, stk, inc;
	logic [24:0]          m25;
	logic [7:0]           ex;
	logic [31:0]          to_bits;
	flt_t                 flt_s5;

	assign sh_c = $signed({2'b00, (fv[30:23] == 8'h00) ? 8'd1 : fv[30:23]})
		+ SB'(FRAC_BITS - 150);

	always_ff @(posedge clk) begin
		if (en) begin
			fneg_s2  <= fv[31];
			nan_s2   <= (fv[30:23] == 8'hFF) && (fv[22:0] != '0);
			inf_s2   <= (fv[30:23] == 8'hFF) && (fv[22:0] == '0);
			man_s2   <= {fv[30:23] != 8'h00, fv[22:0]};
			sh_s2    <= sh_c;
			tsign_s2 <= a[WORD_BITS-1];
			tmag_s2  <= a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
			tzero_s2 <= (a == '0);
		end
	end

	always_comb begin
		nsh   = -sh_s2;
		nn    = nsh[4:0];
		rnd   = 25'(man_s2) + (25'(1) << (nn - 5'd1));
		big_c = inf_s2 || (sh_s2 >= $signed(SB'(WORD_BITS)));
		if (!sh_s2[SB-1])
			mag_c = MW'(man_s2) << sh_s2[PB-1:0];
		else if (nsh > SB'(25))
			mag_c = '0;
		else
			mag_c = MW'(rnd >> nn);
	end

	// leading one of the magnitude
	always_comb begin
		tp_c = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (tmag_s2[i])
				tp_c = PB'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fneg_s3  <= fneg_s2;
			nan_s3   <= nan_s2;
			big_s3   <= big_c;
			mag_s3   <= mag_c;
			tsign_s3 <= tsign_s2;
			tzero_s3 <= tzero_s2;
			tmag_s3  <= tmag_s2;
			tp_s3    <= tp_c;
		end
	end

	always_comb begin
		lim = fneg_s3 ? (MW'(1) << (WORD_BITS - 1)) : ((MW'(1) << (WORD_BITS - 1)) - MW'(1));
		sat = big_s3 || (mag_s3 > lim);
		if (nan_s3)
			fval = '0;
		else if (sat)
			fval = fneg_s3 ? WMIN : WMAX;
		else if (fneg_s3)
			fval = -mag_s3[WORD_BITS-1:0];
		else
			fval = mag_s3[WORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			from_raw_s4 <= 32'(signed'(fval));
			from_ovf_s4 <= nan_s3 || sat;
			tsign_s4    <= tsign_s3;
			tzero_s4    <= tzero_s3;
			tp_s4       <= tp_s3;
			// move the leading one to the top of the word
			norm_s4     <= (NW'(tmag_s3) << 24) << (PB'(WORD_BITS - 1) - tp_s3);
		end
	end

	always_comb begin
		m24 = norm_s4[NW-1 -: 24];
		rb  = norm_s4[WORD_BITS-1];
		stk = |norm_s4[WORD_BITS-2:0];
		inc = rb && (stk || m24[0]);
		m25 = {1'b0, m24} + 25'(inc);
		ex  = 8'(tp_s4) + 8'(127 - FRAC_BITS) + 8'(m25[24]);
		if (tzero_s4)
			to_bits = '0;
		else
			to_bits = {tsign_s4, ex, m25[24] ? 23'd0 : m25[22:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flt_s5.from_raw <= from_raw_s4;
			flt_s5.from_ovf <= from_ovf_s4;
			flt_s5.to_bits  <= to_bits;
		end
	end

	assign flt = flt_s5;

endmodule

>>> hdl/fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed WORD_BITS-bit fixed-point arithmetic, compares and float conversions.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and returns one result per transaction, in
// order. Every operation goes through the same pipeline of WORD_BITS +
// FRAC_BITS + 4 stages; that length is set by the divider, which retires one
// quotient bit per stage. When the output is stalled the whole pipeline holds
// and s_axis_tready drops.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// a_raw[31:0], b_raw[63:32], int_in[95:64], float_in[127:96]
	input  logic [127:0] s_axis_tdata,
	// kind[4:0]
	input  logic [4:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_raw[31:0], result_int[63:32], result_float[95:64],
	// compare_true[96], div_by_zero[97], overflow[98], zero fill[103:99]
	output logic [103:0] m_axis_tdata
);
	import fxa_pkg::*;

	localparam int QB  = WORD_BITS + FRAC_BITS;
	localparam int NST = QB + 4;
	localparam int NDL = QB - 3;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		res_t                 res;
	} lane_t;

	function automatic logic [31:0] sx32(input logic [WORD_BITS-1:0] v);
		sx32 = 32'(signed'(v));
	endfunction

	logic                          en;
	logic [NST:1]                  vld_q;
	logic [KIND_BITS-1:0]          kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic signed [WORD_BITS-1:0]   a_s1, b_s1, iv_s1;
	logic [31:0]                   fv_s1;
	res_t                          simple_c;
	res_t                          res_s2, res_s3, res_s4, res_s5;
	logic signed [2*WORD_BITS-1:0] prod_s2;
	logic signed [2*WORD_BITS-1:0] mshift;
	logic [WORD_BITS:0]            mtop;
	res_t                          mul_c;
	flt_t                          flt_s5;
	lane_t                         lane_c;
	lane_t                         lane_s6;
	lane_t                         lane_pipe_q [0:NDL-1];
	res_t                          div_res;
	res_t                          out_q;

	// advance every stage together unless the finished result is held
	assign en            = !vld_q[NST] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= s_axis_tuser;
			a_s1    <= s_axis_tdata[0 +: WORD_BITS];
			b_s1    <= s_axis_tdata[32 +: WORD_BITS];
			iv_s1   <= s_axis_tdata[64 +: WORD_BITS];
			fv_s1   <= s_axis_tdata[127:96];
		end
	end

	always_comb begin
		simple_c = '0;
		case (kind_s1)
			OP_ADD:     simple_c.result_raw = sx32(a_s1 + b_s1);
			OP_SUB:     simple_c.result_raw = sx32(a_s1 - b_s1);
			OP_GT:      simple_c.compare_true = (a_s1 > b_s1);
			OP_LT:      simple_c.compare_true = (a_s1 < b_s1);
			OP_GE:      simple_c.compare_true = (a_s1 >= b_s1);
			OP_LE:      simple_c.compare_true = (a_s1 <= b_s1);
			OP_EQ:      simple_c.compare_true = (a_s1 == b_s1);
			OP_NE:      simple_c.compare_true = (a_s1 != b_s1);
			OP_MIN:     simple_c.result_raw = sx32((a_s1 < b_s1) ? a_s1 : b_s1);
			OP_MAX:     simple_c.result_raw = sx32((a_s1 > b_s1) ? a_s1 : b_s1);
			OP_INC:     simple_c.result_raw = sx32(a_s1 + WORD_BITS'(1));
			OP_DEC:     simple_c.result_raw = sx32(a_s1 - WORD_BITS'(1));
			OP_FROMINT: simple_c.result_raw = sx32(WORD_BITS'(iv_s1 << FRAC_BITS));
			OP_TOINT:   simple_c.result_int = sx32(a_s1 >>> FRAC_BITS);
			default:    simple_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			res_s2  <= simple_c;
			prod_s2 <= a_s1 * b_s1;
		end
	end

	always_comb begin
		mshift            = prod_s2 >>> FRAC_BITS;
		mtop              = mshift[2*WORD_BITS-1:WORD_BITS-1];
		mul_c             = '0;
		mul_c.result_raw  = sx32(mshift[WORD_BITS-1:0]);
		mul_c.overflow    = !((&mtop) || !(|mtop));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_s2;
			res_s3  <= (kind_s2 == OP_MUL) ? mul_c : res_s2;
			kind_s4 <= kind_s3;
			res_s4  <= res_s3;
			kind_s5 <= kind_s4;
			res_s5  <= res_s4;
		end
	end

	fxa_flt #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_flt (
		.clk(clk),
		.en (en),
		.a  (a_s1),
		.fv (fv_s1),
		.flt(flt_s5)
	);

	fxa_div #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.en (en),
		.a  (a_s1),
		.b  (b_s1),
		.res(div_res)
	);

	always_comb begin
		lane_c.kind = kind_s5;
		lane_c.res  = res_s5;
		case (kind_s5)
			OP_FROMFLOAT: begin
				lane_c.res            = '0;
				lane_c.res.result_raw = flt_s5.from_raw;
				lane_c.res.overflow   = flt_s5.from_ovf;
			end
			OP_TOFLOAT: begin
				lane_c.res              = '0;
				lane_c.res.result_float = flt_s5.to_bits;
			end
			default: lane_c.res = res_s5;
		endcase
	end

	// carry the other results alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			lane_s6        <= lane_c;
			lane_pipe_q[0] <= lane_s6;
			for (int k = 1; k < NDL; k++)
				lane_pipe_q[k] <= lane_pipe_q[k-1];
			out_q <= (lane_pipe_q[NDL-1].kind == OP_DIV) ? div_res : lane_pipe_q[NDL-1].res;
		end
	end

	assign m_axis_tdata = {5'b00000, out_q.overflow, out_q.div_by_zero, out_q.compare_true,
		out_q.result_float, out_q.result_int, out_q.result_raw};

endmodule
